### hdl/lzrle_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the lz/rle stream decompressor
// no dependencies

package lzrle_pkg;

  localparam logic [2:0] CMD_RAW  = 3'd0;
  localparam logic [2:0] CMD_FILL = 3'd1;
  localparam logic [2:0] CMD_ALT  = 3'd2;
  localparam logic [2:0] CMD_INC  = 3'd3;

  localparam logic [7:0]  END_MARKER = 8'hFF;
  localparam logic [2:0]  EXT_PREFIX = 3'd7;
  localparam logic [16:0] COUNT_MAX  = 17'h10000;

  typedef struct packed {
    logic        taken;
    logic        valid;
    logic        from_hist;
    logic [7:0]  value;
    logic [16:0] count;
    logic        finished;
    logic        overflow;
  } item_t;

endpackage

### hdl/lzrle_hist.sv
`timescale 1ns / 1ps
// history ram: sequential write pointer, one registered read port
// same-cycle write/read to one entry is forwarded; uses lzrle_pkg

module lzrle_hist
  import lzrle_pkg::*;
#(
  parameter int HISTORY_ADDR_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [HISTORY_ADDR_BITS-1:0] rd_addr_i,
  output logic [7:0]                   rd_data_o,
  input  logic                         wr_en_i,
  input  logic [7:0]                   wr_data_i
);

  localparam int Depth = 2 ** HISTORY_ADDR_BITS;

  logic [7:0]                   mem [Depth];
  logic [HISTORY_ADDR_BITS-1:0] waddr_q, waddr_d;
  logic [7:0]                   ram_q;
  logic                         fwd_q;
  logic [7:0]                   fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[waddr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      ram_q      <= mem[rd_addr_i];
      fwd_data_q <= wr_data_i;
    end
  end

  assign waddr_d = wr_en_i ? waddr_q + 1'b1 : waddr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waddr_q <= '0;
      fwd_q   <= 1'b0;
    end else begin
      waddr_q <= waddr_d;
      if (rd_en_i) begin
        fwd_q <= wr_en_i && (waddr_q == rd_addr_i);
      end
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : ram_q;

endmodule

### hdl/lzrle_ctrl.sv
`timescale 1ns / 1ps
// stream parser and expansion control, one beat per cycle while step_i is high
// issues history reads for copies; uses lzrle_pkg

module lzrle_ctrl
  import lzrle_pkg::*;
#(
  parameter int HISTORY_ADDR_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i,
  input  logic                         step_i,
  input  logic                         func_i,
  input  logic [7:0]                   data_i,
  output item_t                        item_o,
  output logic                         rd_en_o,
  output logic [HISTORY_ADDR_BITS-1:0] rd_addr_o
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_EXTLEN = 3'd1;
  localparam logic [2:0] PH_ARG1   = 3'd2;
  localparam logic [2:0] PH_ARG2   = 3'd3;
  localparam logic [2:0] PH_RAW    = 3'd4;
  localparam logic [2:0] PH_EMIT   = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;

  localparam logic [16:0] HistSize = 17'(1) << HISTORY_ADDR_BITS;

  logic [2:0]  phase_q, phase_d;
  logic [2:0]  cmd_q, cmd_d;
  logic [10:0] rem_q, rem_d;
  logic [7:0]  fill_low_q, fill_low_d;
  logic [7:0]  fill_high_q, fill_high_d;
  logic        toggle_q, toggle_d;
  logic [15:0] copy_pos_q, copy_pos_d;
  logic [16:0] wpos_q, wpos_d;
  logic        done_q, done_d;
  logic        ovf_q, ovf_d;
  logic        big_endian_q;

  logic        taken, emit, from_hist;
  logic [7:0]  obyte;
  logic [10:0] rem_dec;

  assign rem_dec = rem_q - 11'd1;

  always_comb begin
    phase_d     = phase_q;
    cmd_d       = cmd_q;
    rem_d       = rem_q;
    fill_low_d  = fill_low_q;
    fill_high_d = fill_high_q;
    toggle_d    = toggle_q;
    copy_pos_d  = copy_pos_q;
    wpos_d      = wpos_q;
    done_d      = done_q;
    ovf_d       = ovf_q;
    taken       = 1'b0;
    emit        = 1'b0;
    from_hist   = 1'b0;
    obyte       = 8'h00;
    rd_en_o     = 1'b0;
    if (step_i) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (func_i) begin
            taken = 1'b1;
            if (data_i == END_MARKER) begin
              done_d  = 1'b1;
              phase_d = PH_DONE;
            end else if (data_i[7:5] == EXT_PREFIX) begin
              cmd_d   = data_i[4:2];
              rem_d   = {1'b0, data_i[1:0], 8'h00};
              phase_d = PH_EXTLEN;
            end else begin
              cmd_d    = data_i[7:5];
              rem_d    = {6'd0, data_i[4:0]} + 11'd1;
              toggle_d = 1'b0;
              phase_d  = (cmd_d == CMD_RAW) ? PH_RAW : PH_ARG1;
            end
          end
        end
        PH_EXTLEN: begin
          if (func_i) begin
            taken    = 1'b1;
            rem_d    = {1'b0, rem_q[9:8], data_i} + 11'd1;
            toggle_d = 1'b0;
            phase_d  = (cmd_q == CMD_RAW) ? PH_RAW : PH_ARG1;
          end
        end
        PH_ARG1: begin
          if (func_i) begin
            taken      = 1'b1;
            fill_low_d = data_i;
            phase_d    = (cmd_q == CMD_FILL || cmd_q == CMD_INC) ? PH_EMIT : PH_ARG2;
          end
        end
        PH_ARG2: begin
          if (func_i) begin
            taken = 1'b1;
            if (cmd_q == CMD_ALT) begin
              fill_high_d = data_i;
            end else if (big_endian_q) begin
              copy_pos_d = {fill_low_q, data_i};
            end else begin
              copy_pos_d = {data_i, fill_low_q};
            end
            phase_d = PH_EMIT;
          end
        end
        PH_RAW: begin
          if (func_i) begin
            taken = 1'b1;
            emit  = 1'b1;
            obyte = data_i;
          end
        end
        PH_EMIT: begin
          emit = 1'b1;
          if (cmd_q == CMD_FILL) begin
            obyte = fill_low_q;
          end else if (cmd_q == CMD_ALT) begin
            obyte    = toggle_q ? fill_high_q : fill_low_q;
            toggle_d = ~toggle_q;
          end else if (cmd_q == CMD_INC) begin
            obyte      = fill_low_q;
            fill_low_d = fill_low_q + 8'd1;
          end else begin
            from_hist  = 1'b1;
            rd_en_o    = 1'b1;
            copy_pos_d = copy_pos_q + 16'd1;
          end
        end
        PH_DONE: begin
        end
        default: begin
          phase_d = PH_HEADER;
        end
      endcase
      if (emit) begin
        if (wpos_q >= HistSize) begin
          ovf_d = 1'b1;
        end
        if (wpos_q < COUNT_MAX) begin
          wpos_d = wpos_q + 17'd1;
        end
        rem_d = rem_dec;
        if (rem_dec == 11'd0) begin
          phase_d = PH_HEADER;
        end
      end
    end
  end

  assign rd_addr_o = copy_pos_q[HISTORY_ADDR_BITS-1:0];

  assign item_o.taken     = taken;
  assign item_o.valid     = emit;
  assign item_o.from_hist = from_hist;
  assign item_o.value     = obyte;
  assign item_o.count     = wpos_d;
  assign item_o.finished  = done_d;
  assign item_o.overflow  = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      cmd_q        <= CMD_RAW;
      rem_q        <= '0;
      fill_low_q   <= '0;
      fill_high_q  <= '0;
      toggle_q     <= 1'b0;
      copy_pos_q   <= '0;
      wpos_q       <= '0;
      done_q       <= 1'b0;
      ovf_q        <= 1'b0;
      big_endian_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      cmd_q       <= cmd_d;
      rem_q       <= rem_d;
      fill_low_q  <= fill_low_d;
      fill_high_q <= fill_high_d;
      toggle_q    <= toggle_d;
      copy_pos_q  <= copy_pos_d;
      wpos_q      <= wpos_d;
      done_q      <= done_d;
      ovf_q       <= ovf_d;
      if (cfg_we_i) begin
        big_endian_q <= cfg_wdata_i;
      end
    end
  end

endmodule

### hdl/lz_rle_stream_decompressor.sv
`timescale 1ns / 1ps
// top level of the lz/rle stream decompressor: parser, history ram, output register
// depends on lzrle_pkg, lzrle_ctrl and lzrle_hist
//
// Every input beat yields exactly one output beat, and a new input beat can be taken
// every cycle while the output is not stalled. A beat passes the parser in the cycle it
// is accepted, then a history stage in which a copy reads the 2^HISTORY_ADDR_BITS x 8
// history ram (registered read, forwarded from the byte being written in the same cycle),
// then sits in the output register. Expanded bytes are written to the history ram as they
// leave the history stage. The ram needs no clearing after reset.

module lz_rle_stream_decompressor
  import lzrle_pkg::*;
#(
  parameter int HISTORY_ADDR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte
  input  logic        s_axis_tuser_i,   // func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // out_byte, out_count, finished, overflow, zero pad
  output logic [1:0]  m_axis_tuser_o    // byte_taken, out_valid
);

  item_t                        ctrl_item;
  item_t                        s2_item_q;
  logic                         s2_valid_q;
  logic                         rd_en;
  logic [HISTORY_ADDR_BITS-1:0] rd_addr;
  logic [7:0]                   rd_data;
  logic [7:0]                   s2_byte;
  logic                         out_free, s2_adv, accept, wr_en;
  logic                         m_valid_q;
  logic [31:0]                  m_data_q;
  logic [1:0]                   m_user_q;

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s2_adv          = s2_valid_q && out_free;
  assign s_axis_tready_o = !s2_valid_q || out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_en           = s2_adv && s2_item_q.valid;
  assign s2_byte         = s2_item_q.from_hist ? rd_data : s2_item_q.value;

  lzrle_ctrl #(
    .HISTORY_ADDR_BITS(HISTORY_ADDR_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .step_i     (accept),
    .func_i     (s_axis_tuser_i),
    .data_i     (s_axis_tdata_i),
    .item_o     (ctrl_item),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr)
  );

  lzrle_hist #(
    .HISTORY_ADDR_BITS(HISTORY_ADDR_BITS)
  ) u_hist (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_data_i(s2_byte)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_item_q <= ctrl_item;
    end
    if (s2_adv) begin
      m_data_q <= {5'd0, s2_item_q.overflow, s2_item_q.finished, s2_item_q.count,
                   s2_item_q.valid ? s2_byte : 8'h00};
      m_user_q <= {s2_item_q.valid, s2_item_q.taken};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        s2_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_adv) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

### verif/tb_lz_rle_stream_decompressor.sv
`timescale 1ns / 1ps
// self-checking testbench for lz_rle_stream_decompressor: streams compressed beats,
// predicts every output beat in step with the block and compares field by field
// depends on lzrle_pkg and the lz_rle_stream_decompressor rtl

module tb_lz_rle_stream_decompressor;
  import lzrle_pkg::*;

  localparam int HIST_BITS   = 16;
  localparam int HIST_SIZE   = 1 << HIST_BITS;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 40;

  localparam logic [2:0] CMD_COPY     = 3'd4;
  localparam logic [2:0] CMD_COPY_TOP = 3'd7;

  typedef enum logic [2:0] {
    PARSE_HEADER, PARSE_EXTLEN, PARSE_ARG1, PARSE_ARG2, PARSE_RAW, PARSE_EMIT, PARSE_DONE
  } parse_phase_e;

  typedef struct packed {
    logic        taken;
    logic        emitted;
    logic [7:0]  data;
    logic [16:0] count;
    logic        finished;
    logic        overflow;
  } expansion_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tuser = 1'b0;
  logic [7:0]  s_tdata = '0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  // decoder mirror
  parse_phase_e dec_phase = PARSE_HEADER;
  logic [2:0]   dec_cmd = '0;
  logic [10:0]  run_left = '0;
  logic [7:0]   fill_lo = '0;
  logic [7:0]   fill_hi = '0;
  logic         alt_sel = 1'b0;
  logic [15:0]  copy_at = '0;
  logic [HIST_BITS-1:0] wr_addr = '0;
  logic [16:0]  out_total = '0;
  logic         ended = 1'b0;
  logic         ovf = 1'b0;
  logic         big_endian_copy = 1'b0;
  logic [7:0]   expanded_hist [HIST_SIZE];

  expansion_t   expected_beats [$];
  expansion_t   head_beat;
  logic [15:0]  copy_plan = '0;
  int           cmd_tally [8];
  int           beats_moved = 0;
  int           beats_sent = 0;
  int           beats_checked = 0;
  int           error_count = 0;
  int           cycle_count = 0;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           hold_req = 0;
  int           hold_seen = 0;
  int           hold_left = 0;

  lz_rle_stream_decompressor #(
    .HISTORY_ADDR_BITS(HIST_BITS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d beats outstanding", $time, expected_beats.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void open_body();
    alt_sel = 1'b0;
    cmd_tally[dec_cmd]++;
    dec_phase = (dec_cmd == CMD_RAW) ? PARSE_RAW : PARSE_ARG1;
  endfunction

  function automatic void record_byte(input logic [7:0] v);
    expanded_hist[wr_addr] = v;
    if (int'(out_total) >= HIST_SIZE) ovf = 1'b1;
    wr_addr = wr_addr + 1'b1;
    if (out_total < COUNT_MAX) out_total = out_total + 1'b1;
    run_left = run_left - 1'b1;
    if (run_left == '0) dec_phase = PARSE_HEADER;
  endfunction

  function automatic expansion_t expand_tick(input logic func, input logic [7:0] b);
    expansion_t r;
    r = '0;
    case (dec_phase)
      PARSE_HEADER: begin
        if (func) begin
          r.taken = 1'b1;
          if (b == END_MARKER) begin
            ended = 1'b1;
            dec_phase = PARSE_DONE;
          end else if (b[7:5] == EXT_PREFIX) begin
            dec_cmd = b[4:2];
            run_left = {1'b0, b[1:0], 8'h00};
            dec_phase = PARSE_EXTLEN;
          end else begin
            dec_cmd = b[7:5];
            run_left = 11'(b[4:0]) + 11'd1;
            open_body();
          end
        end
      end
      PARSE_EXTLEN: begin
        if (func) begin
          r.taken = 1'b1;
          run_left = ((run_left & 11'h300) | 11'(b)) + 11'd1;
          open_body();
        end
      end
      PARSE_ARG1: begin
        if (func) begin
          r.taken = 1'b1;
          fill_lo = b;
          dec_phase = (dec_cmd == CMD_FILL || dec_cmd == CMD_INC) ? PARSE_EMIT : PARSE_ARG2;
        end
      end
      PARSE_ARG2: begin
        if (func) begin
          r.taken = 1'b1;
          if (dec_cmd == CMD_ALT) fill_hi = b;
          else if (big_endian_copy) copy_at = {fill_lo, b};
          else copy_at = {b, fill_lo};
          dec_phase = PARSE_EMIT;
        end
      end
      PARSE_RAW: begin
        if (func) begin
          r.taken = 1'b1;
          r.emitted = 1'b1;
          r.data = b;
          record_byte(b);
        end
      end
      PARSE_EMIT: begin
        r.emitted = 1'b1;
        case (dec_cmd)
          CMD_FILL: r.data = fill_lo;
          CMD_ALT: begin
            r.data = alt_sel ? fill_hi : fill_lo;
            alt_sel = ~alt_sel;
          end
          CMD_INC: begin
            r.data = fill_lo;
            fill_lo = fill_lo + 1'b1;
          end
          default: begin
            r.data = expanded_hist[copy_at[HIST_BITS-1:0]];
            copy_at = copy_at + 1'b1;
          end
        endcase
        record_byte(r.data);
      end
      default: ;
    endcase
    if (r.taken || r.emitted) beats_moved++;
    r.count = out_total;
    r.finished = ended;
    r.overflow = ovf;
    return r;
  endfunction

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, what, want, got);
    end
  endtask

  // output side: check each beat, then pick tready for the next edge
  always @(posedge clk_i) begin
    if (rst_n && m_axis_tvalid_o && m_tready) begin
      if (expected_beats.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected beat, expected none actual tdata 0x%0h tuser 0x%0h",
                   $time, m_axis_tdata_o, m_axis_tuser_o);
      end else begin
        head_beat = expected_beats.pop_front();
        beats_checked++;
        compare_field("byte_taken", head_beat.taken, m_axis_tuser_o[0]);
        compare_field("out_valid", head_beat.emitted, m_axis_tuser_o[1]);
        compare_field("out_byte", head_beat.data, m_axis_tdata_o[7:0]);
        compare_field("out_count", head_beat.count, m_axis_tdata_o[24:8]);
        compare_field("finished", head_beat.finished, m_axis_tdata_o[25]);
        compare_field("overflow", head_beat.overflow, m_axis_tdata_o[26]);
        compare_field("tdata pad", '0, m_axis_tdata_o[31:27]);
      end
    end
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_tick(input logic func, input logic [7:0] b);
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    beats_sent++;
    expected_beats.push_back(expand_tick(func, b));
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // offer one byte, then run out any fill or copy it starts
  task automatic feed(input logic [7:0] b);
    send_tick(1'b1, b);
    while (dec_phase == PARSE_EMIT) send_tick(1'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  task automatic settle_results();
    s_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_copy_order(input logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    big_endian_copy = v;
    cfg_we <= 1'b0;
  endtask

  // copy source always inside the part of history already written
  function automatic logic [15:0] pick_copy_source();
    int avail;
    avail = int'(out_total);
    if (avail >= HIST_SIZE) return 16'($urandom_range(HIST_SIZE - 1));
    if ($urandom_range(1)) return 16'(avail - 1 - $urandom_range(avail > 64 ? 63 : avail - 1));
    return 16'($urandom_range(avail - 1));
  endfunction

  task automatic choose_tick(output logic func, output logic [7:0] b);
    logic [2:0] top;
    logic [2:0] cmd;
    logic [1:0] span_hi;
    func = ($urandom_range(99) >= 8);
    b = 8'($urandom_range(255));
    case (dec_phase)
      PARSE_HEADER: begin
        if (func) begin
          top = 3'($urandom_range(7));
          if (top == EXT_PREFIX) begin
            cmd = 3'($urandom_range(7));
            if (cmd >= CMD_COPY && out_total == '0) cmd = CMD_RAW;
            span_hi = ($urandom_range(99) < 80) ? 2'd0 : 2'($urandom_range(3));
            if ({EXT_PREFIX, cmd, span_hi} == END_MARKER) span_hi = 2'd2;
            b = {EXT_PREFIX, cmd, span_hi};
          end else begin
            if (top >= CMD_COPY && out_total == '0) top = CMD_RAW;
            b = {top, $urandom_range(1) ? 5'($urandom_range(3)) : 5'($urandom_range(31))};
          end
        end
      end
      PARSE_ARG1: begin
        if (func && dec_cmd >= CMD_COPY) begin
          copy_plan = pick_copy_source();
          b = big_endian_copy ? copy_plan[15:8] : copy_plan[7:0];
        end
      end
      PARSE_ARG2: begin
        if (func && dec_cmd >= CMD_COPY) b = big_endian_copy ? copy_plan[7:0] : copy_plan[15:8];
      end
      default: func = 1'($urandom_range(1));
    endcase
  endtask

  task automatic test_directed_commands();
    send_tick(1'b0, END_MARKER);
    feed({CMD_RAW, 5'd1});
    feed(8'h00);
    send_tick(1'b0, 8'h55);
    feed(8'hFF);
    feed({CMD_FILL, 5'd0});
    feed(8'hA5);
    feed({CMD_ALT, 5'd2});
    feed(8'h12);
    feed(8'h34);
    feed({CMD_INC, 5'd1});
    feed(8'hFF);
    feed({CMD_COPY, 5'd0});
    feed(8'h00);
    feed(8'h00);
    feed({EXT_PREFIX, CMD_COPY_TOP, 2'b00});
    feed(8'h00);
    feed(8'h03);
    feed(8'h00);
  endtask

  task automatic test_random_stream(input int n);
    int start;
    logic func;
    logic [7:0] b;
    start = beats_moved;
    while (beats_moved - start < n || dec_phase != PARSE_HEADER) begin
      choose_tick(func, b);
      send_tick(func, b);
    end
  endtask

  task automatic test_output_backpressure();
    int saved_pct;
    saved_pct = tx_idle_pct;
    tx_idle_pct = 0;
    hold_req++;
    test_random_stream(120);
    tx_idle_pct = saved_pct;
    settle_results();
  endtask

  task automatic test_end_marker();
    feed(END_MARKER);
    repeat (12) send_tick(1'($urandom_range(1)), $urandom_range(1) ? END_MARKER : 8'h00);
  endtask

  initial begin
    foreach (cmd_tally[k]) cmd_tally[k] = 0;
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    write_copy_order(1'b0);
    tx_idle_pct = 11;
    rx_idle_pct = 67;
    test_directed_commands();
    test_random_stream(320);
    settle_results();
    write_copy_order(1'b1);
    tx_idle_pct = 67;
    rx_idle_pct = 11;
    test_random_stream(320);
    test_output_backpressure();
    write_copy_order(1'b0);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_stream(320);
    test_end_marker();
    settle_results();
    $display("%0d input beats sent, %0d output beats checked, %0d bytes expanded, overflow %0b",
             beats_sent, beats_checked, out_total, ovf);
    $display("commands: raw %0d fill %0d alternate %0d increment %0d copy %0d, both copy orders",
             cmd_tally[CMD_RAW], cmd_tally[CMD_FILL], cmd_tally[CMD_ALT], cmd_tally[CMD_INC],
             cmd_tally[4] + cmd_tally[5] + cmd_tally[6] + cmd_tally[7]);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
